// ===== sv/lru_buffer_pool_manager_core_defines.svh =====
// Assertion macros for the checker file lbpm_checker.sv.
`ifndef LRU_BUFFER_POOL_MANAGER_CORE_DEFINES_SVH
`define LRU_BUFFER_POOL_MANAGER_CORE_DEFINES_SVH
// Holds whenever a holds at the same edge.
`define LBPM_ASSERT_NOW(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("lbpm check failed");
// Holds at the edge after a.
`define LBPM_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("lbpm check failed");
`endif

// ===== sv/lbpm_pkg.sv =====
// Types and codes of the buffer pool manager.
package lbpm_pkg;
	localparam int IDX_W = 6;       // widest frame index / rank
	localparam int CNT_W = 7;       // widest frame count
	localparam int MAX_RESULTS = 16;

	localparam logic [2:0] F_FETCH = 3'd0;
	localparam logic [2:0] F_NEW   = 3'd1;
	localparam logic [2:0] F_UNPIN = 3'd2;
	localparam logic [2:0] F_FLUSH = 3'd3;
	localparam logic [2:0] F_FALL  = 3'd4;

	localparam logic [2:0] ST_HIT    = 3'd0;
	localparam logic [2:0] ST_LOADED = 3'd1;
	localparam logic [2:0] ST_NEW    = 3'd2;
	localparam logic [2:0] ST_PINNED = 3'd3;
	localparam logic [2:0] ST_NORES  = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	localparam logic [1:0] CMD_HIT   = 2'd0;
	localparam logic [1:0] CMD_INST  = 2'd1;
	localparam logic [1:0] CMD_UNPIN = 2'd2;
	localparam logic [1:0] CMD_FLUSH = 2'd3;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] page_id;
		logic        mark_dirty;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  frame;
		logic        need_load;
		logic        writeback;
		logic [31:0] writeback_page;
		logic        last;
	} out_t;

	// search word that walks the cell row
	typedef struct packed {
		logic [2:0]       op;
		logic [31:0]      page;
		logic             mark;
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic [IDX_W-1:0] hit_rank;
		logic             hit_dirty;
		logic             free_v;
		logic [IDX_W-1:0] free_idx;
		logic [CNT_W-1:0] cnt;
		logic             vic_v;
		logic [IDX_W-1:0] vic_idx;
		logic [IDX_W-1:0] vic_rank;
		logic             vic_dirty;
		logic [31:0]      vic_page;
		logic [CNT_W-1:0] fl_cnt;
	} rec_t;

	// update broadcast to every cell
	typedef struct packed {
		logic             en;
		logic [1:0]       kind;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] rank;
		logic [31:0]      page;
		logic             flag;
		logic             evict;
	} cmd_t;
endpackage

// ===== sv/lbpm_cell.sv =====
// One page frame: its state, its search stage and its update logic.
module lbpm_cell import lbpm_pkg::*; #(
	parameter int POOL_FRAMES = 16,
	parameter int PIN_BITS = 16,
	parameter int CELL_IDX = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        hold,
	input  logic        tok_in,
	input  rec_t        rec_in,
	input  cmd_t        cmd,
	output logic        tok_out,
	output rec_t        rec_out,
	output logic        fl_hit,
	output logic [31:0] fl_page
);
	localparam int RW = $clog2(POOL_FRAMES);

	logic                valid_q, dirty_q;
	logic [PIN_BITS-1:0] pins_q;
	logic [31:0]         page_q;
	logic [RW-1:0]       rank_q;
	logic                tok_q;
	rec_t                rec_q, nxt;
	logic                me;
	logic [IDX_W-1:0]    rank_x;

	assign rank_x = IDX_W'(rank_q);
	assign me = (cmd.idx == IDX_W'(CELL_IDX));

	always_comb begin
		nxt = rec_in;
		fl_hit = 1'b0;
		if (valid_q && page_q == rec_in.page && !rec_in.hit) begin
			nxt.hit = 1'b1;
			nxt.hit_idx = IDX_W'(CELL_IDX);
			nxt.hit_rank = rank_x;
			nxt.hit_dirty = dirty_q;
		end
		if (!valid_q && !rec_in.free_v) begin
			nxt.free_v = 1'b1;
			nxt.free_idx = IDX_W'(CELL_IDX);
		end
		if (valid_q)
			nxt.cnt = rec_in.cnt + 1'b1;
		if (valid_q && pins_q == '0 && (!rec_in.vic_v || rank_x > rec_in.vic_rank)) begin
			nxt.vic_v = 1'b1;
			nxt.vic_idx = IDX_W'(CELL_IDX);
			nxt.vic_rank = rank_x;
			nxt.vic_dirty = dirty_q;
			nxt.vic_page = page_q;
		end
		if (rec_in.op == F_FALL && valid_q && dirty_q
				&& rec_in.fl_cnt < CNT_W'(MAX_RESULTS)) begin
			fl_hit = tok_in;
			nxt.fl_cnt = rec_in.fl_cnt + 1'b1;
		end
	end

	assign fl_page = fl_hit ? page_q : 32'd0;
	assign tok_out = tok_q;
	assign rec_out = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (!hold) begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold)
			rec_q <= nxt;
	end

	// page and rank need no reset: read only when valid
	always_ff @(posedge clk) begin
		if (cmd.en) begin
			if (cmd.kind == CMD_HIT) begin
				if (me)
					rank_q <= '0;
				else if (valid_q && rank_x < cmd.rank)
					rank_q <= rank_q + 1'b1;
			end else if (cmd.kind == CMD_INST) begin
				if (me) begin
					rank_q <= '0;
					page_q <= cmd.page;
				end else if (valid_q && !(cmd.evict && rank_x > cmd.rank)) begin
					rank_q <= rank_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
			pins_q <= '0;
		end else if (cmd.en && me) begin
			case (cmd.kind)
				CMD_HIT: begin
					if (pins_q != '1)
						pins_q <= pins_q + 1'b1;
					if (cmd.flag)
						dirty_q <= 1'b1;
				end
				CMD_INST: begin
					valid_q <= 1'b1;
					pins_q <= PIN_BITS'(1);
					dirty_q <= cmd.flag;
				end
				CMD_UNPIN: begin
					if (pins_q != '0)
						pins_q <= pins_q - 1'b1;
					if (cmd.flag)
						dirty_q <= 1'b1;
				end
				default: dirty_q <= 1'b0;
			endcase
		end else if (fl_hit && !hold) begin
			dirty_q <= 1'b0;
		end
	end
endmodule

// ===== sv/lru_buffer_pool_manager_core.sv =====
// An accepted item passes the entry register and every frame cell before its final word is registered.
// A new item is taken only once the final word of the last is out; a stalled output word freezes the row.
// Flush-all: each dirty frame's word leaves when the next dirty frame is found; the final
// one leaves at the row end with last set.
// Reset (arst_n low, async): all frames invalid, clean, unpinned; limit register = 16.
// No clearing pass: the block takes items from the first cycle after reset.
module lru_buffer_pool_manager_core import lbpm_pkg::*; #(
	parameter int POOL_FRAMES = 16,
	parameter int PIN_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_t        in_word,
	output logic       out_valid,
	input  logic       out_stall,
	output out_t       out_word,
	input  logic       cfg_we,
	input  logic [4:0] cfg_data
);
	localparam int IW = $clog2(POOL_FRAMES);

	logic [4:0] lim_cfg_q;
	logic       busy_q, tok0_q, out_v_q, pend_v_q;
	rec_t       rec0_q;
	out_t       out_q, pend_q, res, fl_res;
	cmd_t       cmd;

	logic tok [0:POOL_FRAMES];
	rec_t rec [0:POOL_FRAMES];
	logic [POOL_FRAMES-1:0] fl_hit;
	logic [31:0] fl_pg [0:POOL_FRAMES-1];

	logic            fl_any, tok_end, out_free, hold, accept;
	logic [31:0]     fl_page;
	logic [IW-1:0]   fl_idx;
	logic [CNT_W-1:0] lim;
	rec_t            r;
	rec_t            rec0_d;

	assign accept = in_valid && !in_stall;
	assign in_stall = busy_q;
	assign out_valid = out_v_q;
	assign out_word = out_q;
	assign out_free = !out_v_q || !out_stall;

	// effective limit, clamped to 1..POOL_FRAMES
	always_comb begin
		if (lim_cfg_q == 5'd0)
			lim = CNT_W'(1);
		else if (CNT_W'(lim_cfg_q) > CNT_W'(POOL_FRAMES))
			lim = CNT_W'(POOL_FRAMES);
		else
			lim = CNT_W'(lim_cfg_q);
	end

	// fresh search word for an accepted item
	always_comb begin
		rec0_d = '0;
		rec0_d.op = in_word.func;
		rec0_d.page = in_word.page_id;
		rec0_d.mark = in_word.mark_dirty;
	end

	assign tok[0] = tok0_q;
	assign rec[0] = rec0_q;

	// the cell row: search word hops one frame per cycle while the row is not held
	for (genvar g = 0; g < POOL_FRAMES; g++) begin : g_cell
		lbpm_cell #(
			.POOL_FRAMES(POOL_FRAMES),
			.PIN_BITS(PIN_BITS),
			.CELL_IDX(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.hold(hold),
			.tok_in(tok[g]),
			.rec_in(rec[g]),
			.cmd(cmd),
			.tok_out(tok[g+1]),
			.rec_out(rec[g+1]),
			.fl_hit(fl_hit[g]),
			.fl_page(fl_pg[g])
		);
	end

	// at most one cell holds the search word, so OR-merge its flush report
	always_comb begin
		fl_page = '0;
		fl_idx = '0;
		for (int i = 0; i < POOL_FRAMES; i++) begin
			fl_page = fl_page | fl_pg[i];
			if (fl_hit[i])
				fl_idx = fl_idx | IW'(i);
		end
	end
	assign fl_any = |fl_hit;

	assign tok_end = tok[POOL_FRAMES];
	assign r = rec[POOL_FRAMES];

	// freeze the row while a word has nowhere to go
	assign hold = (tok_end && !out_free) || (fl_any && pend_v_q && !out_free);

	always_comb begin
		fl_res = '0;
		fl_res.status = ST_DONE;
		fl_res.frame = 4'(fl_idx);
		fl_res.writeback = 1'b1;
		fl_res.writeback_page = fl_page;
	end

	// final decision once the search word leaves the last cell
	always_comb begin
		res = '0;
		res.last = 1'b1;
		cmd = '0;
		cmd.page = r.page;
		case (r.op)
			F_FETCH, F_NEW: begin
				if (r.hit) begin
					cmd.en = 1'b1;
					cmd.kind = CMD_HIT;
					cmd.idx = r.hit_idx;
					cmd.rank = r.hit_rank;
					cmd.flag = (r.op == F_NEW);
					res.status = (r.op == F_NEW) ? ST_NEW : ST_HIT;
					res.frame = 4'(r.hit_idx);
				end else if (r.cnt < lim || r.vic_v) begin
					cmd.en = 1'b1;
					cmd.kind = CMD_INST;
					cmd.flag = (r.op == F_NEW);
					cmd.evict = !(r.cnt < lim);
					cmd.idx = (r.cnt < lim) ? r.free_idx : r.vic_idx;
					cmd.rank = r.vic_rank;
					res.status = (r.op == F_NEW) ? ST_NEW : ST_LOADED;
					res.need_load = (r.op == F_FETCH);
					res.frame = 4'(cmd.idx);
					if (!(r.cnt < lim) && r.vic_dirty) begin
						res.writeback = 1'b1;
						res.writeback_page = r.vic_page;
					end
				end else begin
					res.status = ST_PINNED;
				end
			end
			F_UNPIN, F_FLUSH: begin
				if (r.hit) begin
					cmd.en = 1'b1;
					cmd.kind = (r.op == F_UNPIN) ? CMD_UNPIN : CMD_FLUSH;
					cmd.idx = r.hit_idx;
					cmd.flag = r.mark;
					res.status = ST_DONE;
					res.frame = 4'(r.hit_idx);
					if (r.op == F_FLUSH && r.hit_dirty) begin
						res.writeback = 1'b1;
						res.writeback_page = r.page;
					end
				end else begin
					res.status = ST_NORES;
				end
			end
			F_FALL: begin
				res.status = ST_DONE;
				if (pend_v_q) begin
					res = pend_q;
					res.last = 1'b1;
				end
			end
			default: res.status = ST_DONE;
		endcase
		cmd.en = cmd.en && tok_end && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_cfg_q <= 5'd16;
		end else if (cfg_we) begin
			lim_cfg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			tok0_q <= 1'b0;
			out_v_q <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				tok0_q <= 1'b1;
			end else if (!hold) begin
				tok0_q <= 1'b0;
			end
			// final word and flush report never meet: one search word in the row
			if (tok_end && out_free) begin
				out_v_q <= 1'b1;
				busy_q <= 1'b0;
				pend_v_q <= 1'b0;
			end else if (fl_any && !hold) begin
				pend_v_q <= 1'b1;
				if (pend_v_q)
					out_v_q <= 1'b1;
				else if (!out_stall)
					out_v_q <= 1'b0;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			rec0_q <= rec0_d;
		if (tok_end && out_free) begin
			out_q <= res;
		end else if (fl_any && !hold && pend_v_q) begin
			out_q <= pend_q;
		end
		if (fl_any && !hold)
			pend_q <= fl_res;
	end
endmodule

// ===== sv/lbpm_checker.sv =====
// Port-level checks of the buffer pool manager, bound to the top level.
`include "lru_buffer_pool_manager_core_defines.svh"
module lbpm_checker import lbpm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input in_t  in_word,
	input logic out_valid,
	input logic out_stall,
	input out_t out_word
);
	`LBPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
	`LBPM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`LBPM_ASSERT_NOW(a_load_status, out_valid && out_word.need_load, out_word.status == ST_LOADED)
	`LBPM_ASSERT_NOW(a_wb_page_zero, out_valid && !out_word.writeback,
		out_word.writeback_page == 32'd0)
endmodule

bind lru_buffer_pool_manager_core lbpm_checker u_lbpm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.in_word(in_word),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_word(out_word)
);
